FILE: rtl/mssu_pkg.sv
// Package with the signature tables and shared constants of the sector scan unit.
package mssu_pkg;

    localparam int SIG_COUNT = 5;
    localparam int SIG_MAX = 14;
    localparam int WIN_DEPTH = SIG_MAX - 1;
    localparam int IDX_W = 3;
    localparam int ID_W = 16;
    localparam int SCAN_LEN_DEFAULT = 256;

    localparam logic [ID_W-1:0] ID_BASE = 16'h0F1C;

    typedef logic [7:0] byte_t;
    typedef logic [SIG_COUNT-1:0] sig_flags_t;

    localparam int SIG_LEN [SIG_COUNT] = '{14, 11, 11, 11, 11};

    localparam byte_t SIG_BYTES [SIG_COUNT][SIG_MAX] = '{
        '{8'hdb, 8'h83, 8'h2e, 8'h13, 8'h04, 8'h04, 8'hb1,
          8'h06, 8'hcd, 8'h12, 8'hd3, 8'he0, 8'hba, 8'h80},
        '{8'h7c, 8'h8b, 8'hfe, 8'h0e, 8'h07, 8'hb9, 8'hc7,
          8'h00, 8'h26, 8'had, 8'h35, 8'h00, 8'h00, 8'h00},
        '{8'h7c, 8'h89, 8'hfe, 8'h0e, 8'h07, 8'hb9, 8'hc7,
          8'h00, 8'h26, 8'had, 8'h35, 8'h00, 8'h00, 8'h00},
        '{8'h7c, 8'h8b, 8'hfe, 8'h0e, 8'h07, 8'hb9, 8'hc7,
          8'h00, 8'h2e, 8'had, 8'h35, 8'h00, 8'h00, 8'h00},
        '{8'h7c, 8'h89, 8'hfe, 8'h0e, 8'h07, 8'hb9, 8'hc7,
          8'h00, 8'h2e, 8'had, 8'h35, 8'h00, 8'h00, 8'h00}
    };

endpackage

FILE: rtl/multi_signature_sector_scan_unit.sv
// Top level of the multi-signature sector scan unit.
// The unit takes one sector byte per cycle and compares the newest byte and a
// 13-byte history window against five fixed signatures in parallel, so
// consecutive transactions may arrive back to back. Only the first SCAN_LEN
// bytes of a sector are searched, and a match must lie wholly within them.
// The byte marked end_of_sector produces one result transaction in the
// following cycle, held in an output register until taken; the scan state
// returns to its reset value when that byte is accepted. Bytes that do not
// end a sector are accepted even while a result waits; a sector-ending byte
// waits only if the previous result has not been taken yet.
module multi_signature_sector_scan_unit #(
    parameter int SCAN_LEN = mssu_pkg::SCAN_LEN_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_data_byte,
    input  logic                      s_end_of_sector,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_virus_found,
    output logic [mssu_pkg::IDX_W-1:0] m_signature_index,
    output logic [mssu_pkg::ID_W-1:0]  m_signature_id
);

    localparam int POS_W = $clog2(SCAN_LEN + 1);

    mssu_pkg::byte_t                 window_reg [mssu_pkg::WIN_DEPTH];
    logic [POS_W-1:0]                pos_reg;
    mssu_pkg::sig_flags_t            flags_reg;
    mssu_pkg::sig_flags_t            flags_next;
    mssu_pkg::sig_flags_t            hit;
    logic                            in_scan;
    logic                            accept;
    logic                            m_valid_reg;
    logic                            found_reg;
    logic [mssu_pkg::IDX_W-1:0]      index_reg;
    logic [mssu_pkg::ID_W-1:0]       id_reg;
    logic                            found_next;
    logic [mssu_pkg::IDX_W-1:0]      index_next;
    logic [mssu_pkg::ID_W-1:0]       id_next;

    assign s_ready = !m_valid_reg || m_ready || !s_end_of_sector;
    assign accept  = s_valid && s_ready;
    assign in_scan = (pos_reg < POS_W'(SCAN_LEN));

    always_comb begin
        logic ok;
        for (int k = 0; k < mssu_pkg::SIG_COUNT; k++) begin
            ok = (pos_reg >= POS_W'(mssu_pkg::SIG_LEN[k] - 1)) &&
                 (s_data_byte == mssu_pkg::SIG_BYTES[k][mssu_pkg::SIG_LEN[k] - 1]);
            for (int b = 0; b < mssu_pkg::WIN_DEPTH; b++) begin
                if (b < mssu_pkg::SIG_LEN[k] - 1) begin
                    if (window_reg[b] != mssu_pkg::SIG_BYTES[k][mssu_pkg::SIG_LEN[k] - 2 - b]) begin
                        ok = 1'b0;
                    end
                end
            end
            hit[k] = ok;
        end
    end

    assign flags_next = in_scan ? (flags_reg | hit) : flags_reg;

    always_comb begin
        found_next = 1'b0;
        index_next = '0;
        id_next    = '0;
        for (int k = mssu_pkg::SIG_COUNT - 1; k >= 0; k--) begin
            if (flags_next[k]) begin
                found_next = 1'b1;
                index_next = mssu_pkg::IDX_W'(k);
                id_next    = mssu_pkg::ID_BASE + mssu_pkg::ID_W'(k);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            flags_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < mssu_pkg::WIN_DEPTH; i++) begin
                window_reg[i] <= '0;
            end
        end else begin
            if (accept && s_end_of_sector) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                if (s_end_of_sector) begin
                    pos_reg     <= '0;
                    flags_reg   <= '0;
                    for (int i = 0; i < mssu_pkg::WIN_DEPTH; i++) begin
                        window_reg[i] <= '0;
                    end
                end else begin
                    flags_reg <= flags_next;
                    if (in_scan) begin
                        pos_reg       <= pos_reg + POS_W'(1);
                        window_reg[0] <= s_data_byte;
                        for (int i = 1; i < mssu_pkg::WIN_DEPTH; i++) begin
                            window_reg[i] <= window_reg[i-1];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_end_of_sector) begin
            found_reg <= found_next;
            index_reg <= index_next;
            id_reg    <= id_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_virus_found     = found_reg;
    assign m_signature_index = index_reg;
    assign m_signature_id    = id_reg;

endmodule

FILE: rtl/mssu_checker.sv
// Port-level checker for the multi-signature sector scan unit, with its bind.
module mssu_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic [7:0]                 s_data_byte,
    input logic                       s_end_of_sector,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic                       m_virus_found,
    input logic [mssu_pkg::IDX_W-1:0] m_signature_index,
    input logic [mssu_pkg::ID_W-1:0]  m_signature_id
);

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_virus_found) &&
            $stable(m_signature_index) && $stable(m_signature_id))
        else $error("result changed while stalled");

    // A reported ID belongs to the reported signature; with no match both are zero.
    a_id_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_virus_found &&
            m_signature_id == mssu_pkg::ID_BASE + mssu_pkg::ID_W'(m_signature_index) &&
            m_signature_index < mssu_pkg::IDX_W'(mssu_pkg::SIG_COUNT)) ||
            (!m_virus_found && m_signature_index == '0 && m_signature_id == '0))
        else $error("inconsistent result fields");

    // A new result follows only a sector-ending transaction.
    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !$past(m_valid && !m_ready) |->
            $past(s_valid && s_ready && s_end_of_sector))
        else $error("result without end of sector");

    // A byte that does not end the sector never creates a result.
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_end_of_sector && !m_valid |=> !m_valid)
        else $error("unexpected result transaction");

endmodule

bind multi_signature_sector_scan_unit mssu_checker u_mssu_checker (.*);
